// File: rtl/task_scheduler_with_semaphores_defines.svh
// Assertion macros for the task scheduler.
// Included by the top level; no other dependencies.
`ifndef TASK_SCHEDULER_WITH_SEMAPHORES_DEFINES_SVH
`define TASK_SCHEDULER_WITH_SEMAPHORES_DEFINES_SVH

// same-cycle implication
`define TS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task scheduler check failed");

// next-cycle implication
`define TS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task scheduler check failed");

`endif

// File: rtl/tsched_pkg.sv
// Types, constants and defaults shared by the task scheduler modules.
// No dependencies.
package tsched_pkg;

    localparam int TASKS_DEF           = 16;
    localparam int SEMAPHORES_DEF      = 4;
    localparam int QUEUE_DEPTH_DEF     = 8;
    localparam int PRIORITY_LEVELS_DEF = 16;

    localparam int           NREGS     = 4;
    localparam logic [4:0]   SKIP_MAX  = 5'd31;
    localparam logic [7:0]   COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_READY   = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_DELAYED = 2'd3
    } slot_state_t;

    typedef enum logic [2:0] {
        OP_SCHED   = 3'd0,
        OP_TICK    = 3'd1,
        OP_SLEEP   = 3'd2,
        OP_WAIT    = 3'd3,
        OP_POST    = 3'd4,
        OP_CREATE  = 3'd5,
        OP_DESTROY = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef struct packed {
        slot_state_t st;
        logic [31:0] key;
        logic [3:0]  prio;
        logic [4:0]  skip;
        logic [31:0] ticks;
    } slot_entry_t;

    function automatic logic [7:0] sem_reset_val(input int s);
        logic [7:0] v;
        case (s)
            0:       v = 8'd1;
            1:       v = 8'd0;
            2:       v = 8'd5;
            3:       v = 8'd1;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tsched_slot_table.sv
// Task slot table: synchronous memory; read data is valid the cycle after rd_en.
// Per-entry valid bits make never-written entries read as zero. Uses tsched_pkg.
module tsched_slot_table
    import tsched_pkg::*;
#(
    parameter int TASKS = TASKS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(TASKS)-1:0] rd_addr,
    output slot_entry_t              rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(TASKS)-1:0] wr_addr,
    input  slot_entry_t              wr_data
);

    slot_entry_t          mem [TASKS];
    slot_entry_t          rd_q_reg;
    logic                 rd_vld_reg;
    logic [TASKS-1:0]     vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

// File: rtl/task_scheduler_with_semaphores.sv
// Task scheduler with counting semaphores: top level, event sequencer and wait queues.
// Uses tsched_pkg, tsched_slot_table and task_scheduler_with_semaphores_defines.svh.
//
//   channel   | direction | content
//   s_axis    | in        | one kernel event per transfer
//   m_axis    | out       | one result per event
//   cfg       | in        | semaphore count load, no handshake
//
// Schedule visits slots from the one after its last stop, at most TASKS*(PRIORITY_LEVELS+1).
// Tick visits every slot; create and destroy walk every slot, then each semaphore's queue
// entries, then write the slot. Post to a waiting queue wakes its head entry, then shifts
// the rest of that queue down. The slot table read port sets the pace.
// No clearing pass after reset.
// A result waiting on m_axis holds the sequencer at its last step.
module task_scheduler_with_semaphores
    import tsched_pkg::*;
#(
    parameter int TASKS           = TASKS_DEF,
    parameter int SEMAPHORES      = SEMAPHORES_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
    parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[2:0], task_key[34:3], prio[38:35], delay_ticks[70:39], sem_index[72:71]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // task_slot[3:0], accepted[4], caller_blocked[5], none_ready[6]
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

`include "task_scheduler_with_semaphores_defines.svh"

    localparam int SW    = $clog2(TASKS);
    localparam int BOUND = TASKS * (PRIORITY_LEVELS + 1);
    localparam int CW    = $clog2(BOUND);
    localparam int QAW   = $clog2(SEMAPHORES * QUEUE_DEPTH);
    localparam int QLW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SMW   = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_EV   = 9'b000000100,
        S_PG   = 9'b000001000,
        S_PGE  = 9'b000010000,
        S_PQ   = 9'b000100000,
        S_PQE  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    function automatic logic [QAW-1:0] qaddr(input logic [SMW-1:0] s,
                                            input logic [QLW-1:0] i);
        return QAW'(int'(s) * QUEUE_DEPTH + int'(i));
    endfunction

    state_t            state_reg;
    op_t               op_reg;
    logic [31:0]       key_reg;
    logic [3:0]        prio_reg;
    logic [31:0]       delay_reg;
    logic [SMW-1:0]    sem_reg;
    logic [SW-1:0]     ptr_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SW-1:0]     scan_reg;
    logic [SW-1:0]     run_reg;
    logic              mfound_reg;
    logic [SW-1:0]     midx_reg;
    slot_entry_t       ment_reg;
    logic              ffound_reg;
    logic [SW-1:0]     fidx_reg;
    logic [SW-1:0]     tgt_reg;
    slot_entry_t       tent_reg;
    logic [SMW-1:0]    ps_reg;
    logic [QLW-1:0]    pi_reg;
    logic [QLW-1:0]    pk_reg;
    logic [QLW-1:0]    qi_reg;
    logic [SW-1:0]     res_slot_reg;
    logic              res_acc_reg;
    logic              res_blk_reg;
    logic              res_none_reg;
    logic              out_valid_reg;
    logic [3:0]        out_slot_reg;
    logic              out_acc_reg;
    logic              out_blk_reg;
    logic              out_none_reg;
    logic [7:0]        sem_cnt_reg [SEMAPHORES];
    logic [QLW-1:0]    q_len_reg [SEMAPHORES];
    logic [SW-1:0]     qmem [SEMAPHORES * QUEUE_DEPTH];
    logic [SW-1:0]     q_rd_reg;

    logic              slot_re;
    logic [SW-1:0]     slot_ra;
    slot_entry_t       e;
    logic              slot_we;
    logic [SW-1:0]     slot_wa;
    slot_entry_t       slot_wd;
    logic              q_re;
    logic [QAW-1:0]    q_ra;
    logic              q_we;
    logic [QAW-1:0]    q_wa;
    logic [SW-1:0]     q_wd;

    logic              in_xfer;
    logic              out_load;
    logic [2:0]        in_mode;
    logic [31:0]       in_key;
    logic [3:0]        in_prio;
    logic [31:0]       in_delay;
    logic [1:0]        in_sem;
    logic [SMW-1:0]    in_sem_i;
    logic              in_sem_bad;
    logic [SW-1:0]     scan_inc;
    logic [SW-1:0]     ptr_inc;
    logic              ptr_last;
    logic              sch_gt;
    logic              sch_found;
    logic              sch_inc;
    logic              ev_match;
    logic              ev_free;
    logic              m_any;
    logic [SW-1:0]     m_idx;
    slot_entry_t       m_ent;
    logic              f_any;
    logic [SW-1:0]     f_idx;
    logic              wait_ok;
    logic [QLW-1:0]    cur_len;
    logic [QLW-1:0]    pg_len;
    logic              pg_more;

    assign in_mode    = s_axis_tdata[2:0];
    assign in_key     = s_axis_tdata[34:3];
    assign in_prio    = s_axis_tdata[38:35];
    assign in_delay   = s_axis_tdata[70:39];
    assign in_sem     = s_axis_tdata[72:71];
    assign in_sem_i   = SMW'(in_sem);
    assign in_sem_bad = 32'(in_sem) >= 32'(SEMAPHORES);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_none_reg, out_blk_reg, out_acc_reg, out_slot_reg};

    assign scan_inc = (scan_reg == SW'(TASKS - 1)) ? '0 : scan_reg + 1'b1;
    assign ptr_inc  = (ptr_reg == SW'(TASKS - 1)) ? '0 : ptr_reg + 1'b1;
    assign ptr_last = (ptr_reg == SW'(TASKS - 1));

    assign sch_gt    = e.skip > {1'b0, e.prio};
    assign sch_found = sch_gt && (e.st == ST_READY);
    assign sch_inc   = !sch_gt && (e.skip != SKIP_MAX);

    assign ev_match = (e.st != ST_INVALID) && (e.key == key_reg);
    assign ev_free  = (e.st == ST_INVALID);
    assign m_any    = mfound_reg || ev_match;
    assign m_idx    = mfound_reg ? midx_reg : ptr_reg;
    assign m_ent    = mfound_reg ? ment_reg : e;
    assign f_any    = ffound_reg || ev_free;
    assign f_idx    = ffound_reg ? fidx_reg : ptr_reg;

    assign cur_len  = q_len_reg[sem_reg];
    assign wait_ok  = (e.st == ST_READY) && (cur_len < QLW'(QUEUE_DEPTH));
    assign pg_len   = q_len_reg[ps_reg];
    assign pg_more  = pi_reg < pg_len;

    assign slot_re = (state_reg == S_RD);
    assign slot_ra = ptr_reg;

    tsched_slot_table #(
        .TASKS (TASKS)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (slot_re),
        .rd_addr (slot_ra),
        .rd_data (e),
        .wr_en   (slot_we),
        .wr_addr (slot_wa),
        .wr_data (slot_wd)
    );

    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = ptr_reg;
        slot_wd = e;
        q_we    = 1'b0;
        q_wa    = qaddr(sem_reg, cur_len);
        q_wd    = run_reg;
        q_re    = 1'b0;
        q_ra    = qaddr(sem_reg, qi_reg);
        case (state_reg)
            S_EV:
            begin
                case (op_reg)
                    OP_SCHED:
                    begin
                        slot_we      = sch_found || sch_inc;
                        slot_wd.skip = sch_found ? 5'd0 : e.skip + 5'd1;
                    end
                    OP_TICK:
                    begin
                        slot_we = (e.st == ST_DELAYED);
                        if (e.ticks <= 32'd1)
                        begin
                            slot_wd.ticks = '0;
                            slot_wd.st    = ST_READY;
                        end
                        else
                        begin
                            slot_wd.ticks = e.ticks - 32'd1;
                        end
                    end
                    OP_SLEEP:
                    begin
                        slot_we       = (e.st == ST_READY);
                        slot_wd.ticks = delay_reg;
                        slot_wd.st    = ST_DELAYED;
                    end
                    OP_WAIT:
                    begin
                        slot_we    = wait_ok;
                        slot_wd.st = ST_BLOCKED;
                        q_we       = wait_ok;
                    end
                    OP_POST:
                    begin
                        slot_we    = 1'b1;
                        slot_wd.st = ST_READY;
                    end
                    default:
                    begin
                        slot_we = 1'b0;
                    end
                endcase
            end
            S_PG:
            begin
                q_re = pg_more;
                q_ra = qaddr(ps_reg, pi_reg);
            end
            S_PGE:
            begin
                q_we = (q_rd_reg != tgt_reg);
                q_wa = qaddr(ps_reg, pk_reg);
                q_wd = q_rd_reg;
            end
            S_PQ:
            begin
                q_re = qi_reg < cur_len;
            end
            S_PQE:
            begin
                q_we = (qi_reg != '0);
                q_wa = qaddr(sem_reg, qi_reg - 1'b1);
                q_wd = q_rd_reg;
            end
            S_FIN:
            begin
                slot_we = 1'b1;
                slot_wa = tgt_reg;
                if (op_reg == OP_CREATE)
                begin
                    slot_wd.st    = ST_READY;
                    slot_wd.key   = key_reg;
                    slot_wd.prio  = prio_reg;
                    slot_wd.skip  = '0;
                    slot_wd.ticks = '0;
                end
                else
                begin
                    slot_wd    = tent_reg;
                    slot_wd.st = ST_INVALID;
                end
            end
            default:
            begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_wa] <= q_wd;
        end
        if (q_re)
        begin
            q_rd_reg <= qmem[q_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            scan_reg      <= SW'(TASKS - 1);
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SEMAPHORES; s++)
            begin
                sem_cnt_reg[s] <= sem_reset_val(s);
                q_len_reg[s]   <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg       <= op_t'(in_mode);
                        key_reg      <= in_key;
                        prio_reg     <= (32'(in_prio) >= 32'(PRIORITY_LEVELS)) ?
                                        4'(PRIORITY_LEVELS - 1) : in_prio;
                        delay_reg    <= in_delay;
                        sem_reg      <= in_sem_i;
                        cnt_reg      <= '0;
                        mfound_reg   <= 1'b0;
                        ffound_reg   <= 1'b0;
                        res_slot_reg <= '0;
                        res_acc_reg  <= 1'b0;
                        res_blk_reg  <= 1'b0;
                        res_none_reg <= 1'b0;
                        state_reg    <= S_DONE;
                        case (op_t'(in_mode))
                            OP_SCHED:
                            begin
                                ptr_reg   <= scan_inc;
                                state_reg <= S_RD;
                            end
                            OP_TICK, OP_CREATE, OP_DESTROY:
                            begin
                                ptr_reg   <= '0;
                                state_reg <= S_RD;
                            end
                            OP_SLEEP:
                            begin
                                ptr_reg   <= run_reg;
                                state_reg <= S_RD;
                            end
                            OP_WAIT:
                            begin
                                if (!in_sem_bad)
                                begin
                                    if (sem_cnt_reg[in_sem_i] != 8'd0)
                                    begin
                                        sem_cnt_reg[in_sem_i] <= sem_cnt_reg[in_sem_i] - 8'd1;
                                        res_acc_reg           <= 1'b1;
                                    end
                                    else
                                    begin
                                        ptr_reg   <= run_reg;
                                        state_reg <= S_RD;
                                    end
                                end
                            end
                            OP_POST:
                            begin
                                if (!in_sem_bad)
                                begin
                                    if (sem_cnt_reg[in_sem_i] == 8'd0 &&
                                        q_len_reg[in_sem_i] != '0)
                                    begin
                                        qi_reg    <= '0;
                                        state_reg <= S_PQ;
                                    end
                                    else if (sem_cnt_reg[in_sem_i] != COUNT_MAX)
                                    begin
                                        sem_cnt_reg[in_sem_i] <= sem_cnt_reg[in_sem_i] + 8'd1;
                                        res_acc_reg           <= 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    state_reg <= S_DONE;
                    case (op_reg)
                        OP_SCHED:
                        begin
                            if (sch_found)
                            begin
                                scan_reg     <= ptr_reg;
                                run_reg      <= ptr_reg;
                                res_slot_reg <= ptr_reg;
                                res_acc_reg  <= 1'b1;
                            end
                            else if (cnt_reg == CW'(BOUND - 1))
                            begin
                                scan_reg     <= ptr_reg;
                                res_none_reg <= 1'b1;
                            end
                            else
                            begin
                                cnt_reg   <= cnt_reg + 1'b1;
                                ptr_reg   <= ptr_inc;
                                state_reg <= S_RD;
                            end
                        end
                        OP_TICK:
                        begin
                            if (ptr_last)
                            begin
                                res_acc_reg <= 1'b1;
                            end
                            else
                            begin
                                ptr_reg   <= ptr_inc;
                                state_reg <= S_RD;
                            end
                        end
                        OP_SLEEP:
                        begin
                            res_acc_reg <= (e.st == ST_READY);
                        end
                        OP_WAIT:
                        begin
                            if (wait_ok)
                            begin
                                q_len_reg[sem_reg] <= cur_len + 1'b1;
                                res_acc_reg        <= 1'b1;
                                res_blk_reg        <= 1'b1;
                            end
                        end
                        OP_POST:
                        begin
                            qi_reg    <= QLW'(1);
                            state_reg <= S_PQ;
                        end
                        OP_CREATE, OP_DESTROY:
                        begin
                            mfound_reg <= m_any;
                            midx_reg   <= m_idx;
                            ment_reg   <= m_ent;
                            ffound_reg <= f_any;
                            fidx_reg   <= f_idx;
                            ps_reg     <= '0;
                            pi_reg     <= '0;
                            pk_reg     <= '0;
                            tent_reg   <= m_ent;
                            if (!ptr_last)
                            begin
                                ptr_reg   <= ptr_inc;
                                state_reg <= S_RD;
                            end
                            else if (m_any)
                            begin
                                tgt_reg   <= m_idx;
                                state_reg <= S_PG;
                            end
                            else if (f_any && op_reg == OP_CREATE)
                            begin
                                tgt_reg   <= f_idx;
                                state_reg <= S_PG;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_PG:
                begin
                    if (pg_more)
                    begin
                        state_reg <= S_PGE;
                    end
                    else
                    begin
                        q_len_reg[ps_reg] <= pk_reg;
                        pi_reg            <= '0;
                        pk_reg            <= '0;
                        if (ps_reg == SMW'(SEMAPHORES - 1))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            ps_reg <= ps_reg + 1'b1;
                        end
                    end
                end
                S_PGE:
                begin
                    if (q_rd_reg != tgt_reg)
                    begin
                        pk_reg <= pk_reg + 1'b1;
                    end
                    pi_reg    <= pi_reg + 1'b1;
                    state_reg <= S_PG;
                end
                S_PQ:
                begin
                    if (qi_reg < cur_len)
                    begin
                        state_reg <= S_PQE;
                    end
                    else
                    begin
                        q_len_reg[sem_reg] <= cur_len - 1'b1;
                        res_acc_reg        <= 1'b1;
                        state_reg          <= S_DONE;
                    end
                end
                S_PQE:
                begin
                    if (qi_reg == '0)
                    begin
                        ptr_reg   <= q_rd_reg;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        qi_reg    <= qi_reg + 1'b1;
                        state_reg <= S_PQ;
                    end
                end
                S_FIN:
                begin
                    res_acc_reg  <= 1'b1;
                    res_slot_reg <= (op_reg == OP_CREATE) ? tgt_reg : '0;
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr_en && (32'(cfg_index) < 32'(SEMAPHORES)))
            begin
                sem_cnt_reg[SMW'(cfg_index)] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_slot_reg <= 4'(res_slot_reg);
            out_acc_reg  <= res_acc_reg;
            out_blk_reg  <= res_blk_reg;
            out_none_reg <= res_none_reg;
        end
    end

    `TS_ASSERT_IMP(a_blk_needs_acc, clk, rst_n, out_valid_reg && out_blk_reg, out_acc_reg)
    `TS_ASSERT_IMP(a_none_not_acc, clk, rst_n, out_valid_reg && out_none_reg, !out_acc_reg)
    `TS_ASSERT_NXT(a_busy_after_xfer, clk, rst_n, in_xfer, state_reg != S_IDLE)

endmodule

// File: verif/testbench.sv
// Self-checking testbench for task_scheduler_with_semaphores: a queue-fed driver and a
// checking monitor around an in-bench kernel table predictor.
// Depends on tsched_pkg and the task_scheduler_with_semaphores RTL.
`timescale 1ns / 1ps

module testbench;
    import tsched_pkg::*;

    localparam int NSLOT    = 16;
    localparam int NSEM     = 4;
    localparam int QDEPTH   = 8;
    localparam int NPRIO    = 16;
    localparam int WATCHDOG = 6000;

    typedef struct {
        op_t         mode;
        logic [31:0] key;
        logic [3:0]  prio;
        logic [31:0] delay;
        logic [1:0]  sem;
        bit          drain;
    } kevent_t;

    typedef struct packed {
        logic       none;
        logic       blk;
        logic       acc;
        logic [3:0] slot;
    } kresult_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    kevent_t  pending_events[$];
    kresult_t expected_results[$];
    kevent_t  in_flight;
    int       errors = 0;
    int       results_seen = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;
    int       stall_pct = 0;
    int       pattern_left = 0;

    // kernel table copy
    slot_state_t tbl_state[NSLOT];
    logic [31:0] tbl_key[NSLOT];
    logic [3:0]  tbl_prio[NSLOT];
    logic [4:0]  tbl_skip[NSLOT];
    logic [31:0] tbl_ticks[NSLOT];
    int          cur_slot;
    int          last_pick;
    logic [7:0]  sem_cnt[NSEM];
    int          waiters[NSEM][$];
    logic [31:0] key_pool[24];

    always #5 clk = ~clk;

    task_scheduler_with_semaphores i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic void purge_slot(int slot);
        for (int s = 0; s < NSEM; s++)
            for (int i = waiters[s].size() - 1; i >= 0; i--)
                if (waiters[s][i] == slot)
                    waiters[s].delete(i);
    endfunction

    function automatic int lookup_key(logic [31:0] key);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_state[i] != ST_INVALID && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic kresult_t apply_event(kevent_t ev);
        kresult_t r;
        int       p;
        int       f;
        bit       found;
        r = '0;
        case (ev.mode)
            OP_SCHED: begin
                found = 1'b0;
                p = last_pick;
                for (int n = 0; n < NSLOT * (NPRIO + 1) && !found; n++) begin
                    p = (p + 1 >= NSLOT) ? 0 : p + 1;
                    if (tbl_skip[p] > {1'b0, tbl_prio[p]}) begin
                        if (tbl_state[p] == ST_READY)
                            found = 1'b1;
                    end else if (tbl_skip[p] < SKIP_MAX) begin
                        tbl_skip[p]++;
                    end
                end
                last_pick = p;
                if (found) begin
                    tbl_skip[p] = '0;
                    cur_slot = p;
                    r.slot = p[3:0];
                    r.acc = 1'b1;
                end else begin
                    r.none = 1'b1;
                end
            end
            OP_TICK: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_state[i] == ST_DELAYED) begin
                        if (tbl_ticks[i] <= 32'd1) begin
                            tbl_ticks[i] = '0;
                            tbl_state[i] = ST_READY;
                        end else begin
                            tbl_ticks[i]--;
                        end
                    end
                r.acc = 1'b1;
            end
            OP_SLEEP: begin
                if (tbl_state[cur_slot] == ST_READY) begin
                    tbl_ticks[cur_slot] = ev.delay;
                    tbl_state[cur_slot] = ST_DELAYED;
                    r.acc = 1'b1;
                end
            end
            OP_WAIT: begin
                if (sem_cnt[ev.sem] > 0) begin
                    sem_cnt[ev.sem]--;
                    r.acc = 1'b1;
                end else if (tbl_state[cur_slot] == ST_READY &&
                             waiters[ev.sem].size() < QDEPTH) begin
                    tbl_state[cur_slot] = ST_BLOCKED;
                    waiters[ev.sem].push_back(cur_slot);
                    r.acc = 1'b1;
                    r.blk = 1'b1;
                end
            end
            OP_POST: begin
                if (sem_cnt[ev.sem] == 0 && waiters[ev.sem].size() > 0) begin
                    tbl_state[waiters[ev.sem].pop_front()] = ST_READY;
                    r.acc = 1'b1;
                end else if (sem_cnt[ev.sem] < COUNT_MAX) begin
                    sem_cnt[ev.sem]++;
                    r.acc = 1'b1;
                end
            end
            OP_CREATE: begin
                f = lookup_key(ev.key);
                if (f < 0)
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (tbl_state[i] == ST_INVALID)
                            f = i;
                if (f >= 0) begin
                    purge_slot(f);
                    tbl_state[f] = ST_READY;
                    tbl_key[f] = ev.key;
                    tbl_prio[f] = ev.prio;
                    tbl_skip[f] = '0;
                    tbl_ticks[f] = '0;
                    r.slot = f[3:0];
                    r.acc = 1'b1;
                end
            end
            OP_DESTROY: begin
                f = lookup_key(ev.key);
                if (f >= 0) begin
                    tbl_state[f] = ST_INVALID;
                    purge_slot(f);
                    r.acc = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_event(in_flight));
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_events.size() > 0 &&
                         !(pending_events[0].drain && expected_results.size() > 0))
                begin
                    in_flight = pending_events.pop_front();
                    s_axis_tdata <= {7'd0, in_flight.sem, in_flight.delay, in_flight.prio,
                                     in_flight.key, in_flight.mode};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        kresult_t got;
        kresult_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[6:0];
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.slot !== want.slot)
                    begin
                        errors++;
                        $display("%0t: task_slot expected %0d actual %0d", $time,
                                 want.slot, got.slot);
                    end
                    if (got.acc !== want.acc)
                    begin
                        errors++;
                        $display("%0t: accepted expected %0b actual %0b", $time,
                                 want.acc, got.acc);
                    end
                    if (got.blk !== want.blk)
                    begin
                        errors++;
                        $display("%0t: caller_blocked expected %0b actual %0b", $time,
                                 want.blk, got.blk);
                    end
                    if (got.none !== want.none)
                    begin
                        errors++;
                        $display("%0t: none_ready expected %0b actual %0b", $time,
                                 want.none, got.none);
                    end
                end
            end
            if (!hold_done && results_seen == 400)
            begin
                hold_done = 1'b1;
                hold_left = 1500;
            end
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(16, 128);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            else
                pattern_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_event(op_t mode, logic [31:0] key, logic [3:0] prio,
                             logic [31:0] delay, logic [1:0] sem, bit drain = 1'b0);
        kevent_t ev;
        ev.mode = mode;
        ev.key = key;
        ev.prio = prio;
        ev.delay = delay;
        ev.sem = sem;
        ev.drain = drain;
        pending_events.push_back(ev);
    endtask

    task automatic wait_idle();
        while (pending_events.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_sem_reg(int idx, logic [7:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sem_cnt[idx] = value;
    endtask

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'd0;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic add_random_burst();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0, 1: add_event(OP_CREATE, key_pool[$urandom_range(0, 23)],
                                $urandom_range(0, 15), $urandom, $urandom);
                2, 3: begin
                    add_event(OP_SCHED, $urandom, $urandom, $urandom, $urandom);
                    add_event(OP_WAIT, $urandom, $urandom, $urandom, $urandom_range(0, 3));
                end
                4: begin
                    add_event(OP_SCHED, $urandom, $urandom, $urandom, $urandom);
                    add_event(OP_SLEEP, $urandom, $urandom, pick_delay(), $urandom);
                end
                5: add_event(OP_POST, $urandom, $urandom, $urandom, $urandom_range(0, 3));
                6: add_event(OP_TICK, $urandom, $urandom, $urandom, $urandom);
                7: add_event(OP_DESTROY, ($urandom_range(0, 4) == 0) ? $urandom :
                             key_pool[$urandom_range(0, 23)], $urandom, $urandom, $urandom);
                default: add_event(op_t'($urandom_range(0, 7)), $urandom, $urandom,
                                   $urandom, $urandom);
            endcase
        end
    endtask

    initial
    begin
        int setting;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_state[i] = ST_INVALID;
            tbl_key[i] = '0;
            tbl_prio[i] = '0;
            tbl_skip[i] = '0;
            tbl_ticks[i] = '0;
        end
        for (int s = 0; s < NSEM; s++)
            sem_cnt[s] = sem_reset_val(s);
        cur_slot = 0;
        last_pick = NSLOT - 1;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 24; i++)
            key_pool[i] = $urandom;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_event(OP_SCHED, 32'h0, 4'd0, 32'h0, 2'd0);
        add_event(OP_SLEEP, 32'h0, 4'd0, 32'd3, 2'd0);
        add_event(OP_CREATE, 32'h0, 4'd0, 32'hFFFF_FFFF, 2'd3);
        add_event(OP_CREATE, 32'hFFFF_FFFF, 4'd15, 32'h0, 2'd0);
        add_event(OP_CREATE, 32'h0, 4'd7, 32'h0, 2'd0);
        add_event(OP_SCHED, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 2'd3);
        add_event(OP_WAIT, 32'h0, 4'd0, 32'h0, 2'd0);
        add_event(OP_WAIT, 32'h0, 4'd0, 32'h0, 2'd1);
        add_event(OP_WAIT, 32'h0, 4'd0, 32'h0, 2'd1);
        add_event(OP_POST, 32'h0, 4'd0, 32'h0, 2'd1);
        add_event(OP_POST, 32'h0, 4'd0, 32'h0, 2'd2);
        add_event(OP_SCHED, 32'h0, 4'd0, 32'h0, 2'd0);
        add_event(OP_SLEEP, 32'h0, 4'd0, 32'd0, 2'd0);
        add_event(OP_TICK, 32'h0, 4'd0, 32'h0, 2'd0);
        add_event(OP_SCHED, 32'h0, 4'd0, 32'h0, 2'd0);
        add_event(OP_SLEEP, 32'h0, 4'd0, 32'hFFFF_FFFF, 2'd0);
        add_event(OP_TICK, 32'h0, 4'd0, 32'h0, 2'd0);
        add_event(OP_DESTROY, 32'h1234_5678, 4'd0, 32'h0, 2'd0);
        add_event(OP_DESTROY, 32'hFFFF_FFFF, 4'd0, 32'h0, 2'd0);
        add_event(OP_WAIT, 32'h0, 4'd0, 32'h0, 2'd3);
        add_event(OP_NONE, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 2'd3);
        add_event(OP_SCHED, 32'h0, 4'd0, 32'h0, 2'd0);
        wait_idle();

        for (setting = 0; setting < 5; setting++)
        begin
            for (int r = 0; r < NSEM; r++)
                case (setting)
                    0:       write_sem_reg(r, 8'd0);
                    1:       write_sem_reg(r, 8'hFF);
                    2:       write_sem_reg(r, (r % 2 == 0) ? 8'd0 : 8'hFE);
                    default: write_sem_reg(r, $urandom_range(0, 3));
                endcase
            while (pending_events.size() < 260)
                add_random_burst();
            add_event(OP_TICK, $urandom, $urandom, $urandom, $urandom, 1'b1);
            while (pending_events.size() < 270)
                add_random_burst();
            wait_idle();
        end

        repeat (600) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tsched_pkg.sv
rtl/tsched_slot_table.sv
rtl/task_scheduler_with_semaphores.sv
verif/testbench.sv
